### sv/blmp_pkg.sv
package blmp_pkg;

  localparam int ADDR_BITS = 23;
  localparam int WORD_BITS = ADDR_BITS - 3;
  localparam int BANK_BITS = ADDR_BITS - 4;
  localparam int INV_BITS  = 23;

  typedef enum logic [2:0] {
    OP_READ     = 3'd0,
    OP_WRITE    = 3'd1,
    OP_MASKED   = 3'd2,
    OP_REG_READ = 3'd3,
    OP_FETCH    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    SZ_BYTE  = 2'd0,
    SZ_HALF  = 2'd1,
    SZ_WORD  = 2'd2,
    SZ_DWORD = 2'd3
  } size_t;

  typedef struct packed {
    op_t                   op;
    size_t                 size;
    logic [ADDR_BITS-1:0]  addr;
    logic [3:0]            reg_idx;
    logic [63:0]           wdata;
    logic [63:0]           wmask;
  } lane_req_t;

  typedef struct packed {
    logic [63:0]          read_data;
    logic                 wr;
    logic [63:0]          even_wdata;
    logic [63:0]          odd_wdata;
    logic [INV_BITS-1:0]  inv_addr;
  } lane_rsp_t;

  // Storage byte address after alignment (masked ops only) and the big-endian lane swizzle (all ops but fetch).
  function automatic logic [ADDR_BITS-1:0] addr_swz(op_t op, size_t size,
                                                    logic [31:0] address);
    logic [ADDR_BITS-1:0] a;
    a = address[ADDR_BITS-1:0];
    if (op == OP_MASKED) begin
      case (size)
        SZ_HALF:  a[0]   = 1'b0;
        SZ_WORD:  a[1:0] = 2'b00;
        SZ_DWORD: a[2:0] = 3'b000;
        default:  a      = a;
      endcase
    end
    if (op != OP_FETCH) begin
      case (size)
        SZ_BYTE: a[1:0] = a[1:0] ^ 2'b11;
        SZ_HALF: a[1]   = ~a[1];
        default: a      = a;
      endcase
    end
    return a;
  endfunction

  function automatic logic [INV_BITS-1:0] inv_addr(logic [ADDR_BITS-1:0] a);
    logic [ADDR_BITS+INV_BITS-1:0] t;
    t = {{INV_BITS{1'b0}}, a};
    return t[INV_BITS-1:0];
  endfunction

  function automatic logic [31:0] ident_word(logic [3:0] idx);
    logic [31:0] w;
    unique case (idx)
      4'd0:    w = 32'hB419_0010;
      4'd2:    w = 32'h2B3B_1A0B;
      4'd6:    w = 32'h101C_0A04;
      default: w = 32'h0;
    endcase
    return w;
  endfunction

endpackage

### sv/blmp_ifs.sv
interface blmp_in_if;
  import blmp_pkg::*;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [1:0]  xfer_size;
  logic [31:0] address;
  logic [63:0] write_data;
  logic [63:0] write_mask;

  modport source (output valid, operation, xfer_size, address, write_data, write_mask,
                  input ready);
  modport sink (input valid, operation, xfer_size, address, write_data, write_mask,
                output ready);
endinterface

interface blmp_out_if;
  import blmp_pkg::*;
  logic                valid;
  logic                ready;
  logic signed [63:0]  read_data;
  logic                invalidate_valid;
  logic [INV_BITS-1:0] invalidate_address;

  modport source (output valid, read_data, invalidate_valid, invalidate_address,
                  input ready);
  modport sink (input valid, read_data, invalidate_valid, invalidate_address,
                output ready);
endinterface

### sv/blmp_ram.sv
module blmp_ram #(
  parameter int ADDR_W = 19,
  parameter int DATA_W = 64
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/blmp_lane.sv
module blmp_lane
  import blmp_pkg::*;
(
  input  lane_req_t   req,
  input  logic [63:0] even_rdata,
  input  logic [63:0] odd_rdata,
  output lane_rsp_t   rsp
);

  logic         lo_odd;
  logic [127:0] window;
  logic [127:0] bit_en;
  logic [127:0] ins;
  logic [127:0] merged;
  logic [5:0]   sh;
  logic [15:0]  be16;
  logic [7:0]   byte_en;
  logic [63:0]  le_old;
  logic [63:0]  size_mask;
  logic [63:0]  ordered_old;
  logic [63:0]  sext;
  logic [63:0]  new_val;
  logic [63:0]  le_new;

  always_comb begin
    lo_odd = req.addr[3];
    window = lo_odd ? {even_rdata, odd_rdata} : {odd_rdata, even_rdata};
    sh     = {req.addr[2:0], 3'b000};
    le_old = window[63:0];
    le_old = 64'(window >> sh);

    case (req.size)
      SZ_BYTE: begin size_mask = 64'h0000_0000_0000_00FF; byte_en = 8'h01; end
      SZ_HALF: begin size_mask = 64'h0000_0000_0000_FFFF; byte_en = 8'h03; end
      SZ_WORD: begin size_mask = 64'h0000_0000_FFFF_FFFF; byte_en = 8'h0F; end
      default: begin size_mask = 64'hFFFF_FFFF_FFFF_FFFF; byte_en = 8'hFF; end
    endcase

    ordered_old = (req.size == SZ_DWORD) ? {le_old[31:0], le_old[63:32]}
                                         : (le_old & size_mask);
    case (req.size)
      SZ_BYTE: sext = {{56{le_old[7]}}, le_old[7:0]};
      SZ_HALF: sext = {{48{le_old[15]}}, le_old[15:0]};
      SZ_WORD: sext = {{32{le_old[31]}}, le_old[31:0]};
      default: sext = ordered_old;
    endcase

    new_val = req.wdata & size_mask;
    if (req.op == OP_MASKED) begin
      new_val = ((new_val & req.wmask) | (ordered_old & ~req.wmask)) & size_mask;
    end
    le_new = (req.size == SZ_DWORD) ? {new_val[31:0], new_val[63:32]} : new_val;

    be16 = 16'(byte_en) << req.addr[2:0];
    for (int i = 0; i < 16; i++) begin
      bit_en[i*8 +: 8] = {8{be16[i]}};
    end
    ins    = 128'(le_new) << sh;
    merged = (window & ~bit_en) | (ins & bit_en);

    rsp.even_wdata = lo_odd ? merged[127:64] : merged[63:0];
    rsp.odd_wdata  = lo_odd ? merged[63:0]   : merged[127:64];
    rsp.read_data  = '0;
    rsp.wr         = 1'b0;
    rsp.inv_addr   = '0;

    unique case (req.op) inside
      OP_READ:     rsp.read_data = sext;
      OP_WRITE, OP_MASKED: begin
        rsp.wr       = 1'b1;
        rsp.inv_addr = inv_addr(req.addr);
      end
      OP_REG_READ: rsp.read_data = {32'h0, ident_word(req.reg_idx)};
      OP_FETCH:    rsp.read_data = le_old;
      default:     rsp.read_data = '0;
    endcase
  end

endmodule

### sv/byte_lane_memory_port_unit.sv
// An accepted word is read from both memory banks into their read registers, then
// merged and written back before the next word is taken; its result is held in the
// output register while out_ch stalls, which also holds off the next word.
// Reset: synchronous, active low. After reset the storage is cleared one row per
// cycle across both banks, 2^(ADDR_BITS-4) rows (524288 at 23 address bits),
// and in_ch.ready stays low until the clear completes.
module byte_lane_memory_port_unit
  import blmp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  blmp_in_if.sink     in_ch,
  blmp_out_if.source  out_ch
);

  logic                 clr_active_r;
  logic [BANK_BITS-1:0] clr_idx_r;
  logic                 s1_valid_r;
  lane_req_t            req_r;
  lane_req_t            req_nxt;
  logic [BANK_BITS-1:0] even_idx_r, even_idx_nxt;
  logic [BANK_BITS-1:0] odd_idx_r, odd_idx_nxt;
  logic                 out_valid_r;
  logic [63:0]          out_data_r;
  logic                 out_inv_r;
  logic [INV_BITS-1:0]  out_inv_addr_r;

  logic                 accept;
  logic                 s1_done;
  logic [WORD_BITS-1:0] word_in;
  logic [63:0]          even_rdata, odd_rdata;
  logic                 bank_we;
  logic [BANK_BITS-1:0] even_waddr, odd_waddr;
  logic [63:0]          even_wdata, odd_wdata;
  lane_rsp_t            rsp;

  assign in_ch.ready = !clr_active_r && !s1_valid_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign s1_done     = s1_valid_r && (!out_valid_r || out_ch.ready);

  always_comb begin
    req_nxt.op      = op_t'(in_ch.operation);
    req_nxt.size    = size_t'(in_ch.xfer_size);
    req_nxt.addr    = addr_swz(op_t'(in_ch.operation), size_t'(in_ch.xfer_size),
                               in_ch.address);
    req_nxt.reg_idx = in_ch.address[5:2];
    req_nxt.wdata   = in_ch.write_data;
    req_nxt.wmask   = in_ch.write_mask;
    word_in         = req_nxt.addr[ADDR_BITS-1:3];
    odd_idx_nxt     = word_in[WORD_BITS-1:1];
    even_idx_nxt    = word_in[WORD_BITS-1:1] + BANK_BITS'(word_in[0]);
  end

  always_comb begin
    if (clr_active_r) begin
      bank_we    = 1'b1;
      even_waddr = clr_idx_r;
      odd_waddr  = clr_idx_r;
      even_wdata = '0;
      odd_wdata  = '0;
    end else begin
      bank_we    = s1_done && rsp.wr;
      even_waddr = even_idx_r;
      odd_waddr  = odd_idx_r;
      even_wdata = rsp.even_wdata;
      odd_wdata  = rsp.odd_wdata;
    end
  end

  blmp_ram #(.ADDR_W(BANK_BITS), .DATA_W(64)) u_even_bank (
    .clk   (clk),
    .we    (bank_we),
    .waddr (even_waddr),
    .wdata (even_wdata),
    .re    (accept),
    .raddr (even_idx_nxt),
    .rdata (even_rdata)
  );

  blmp_ram #(.ADDR_W(BANK_BITS), .DATA_W(64)) u_odd_bank (
    .clk   (clk),
    .we    (bank_we),
    .waddr (odd_waddr),
    .wdata (odd_wdata),
    .re    (accept),
    .raddr (odd_idx_nxt),
    .rdata (odd_rdata)
  );

  blmp_lane u_lane (
    .req        (req_r),
    .even_rdata (even_rdata),
    .odd_rdata  (odd_rdata),
    .rsp        (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_idx_r    <= '0;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (clr_active_r) begin
        clr_idx_r <= clr_idx_r + BANK_BITS'(1);
        if (&clr_idx_r) begin
          clr_active_r <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_done) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r      <= req_nxt;
      even_idx_r <= even_idx_nxt;
      odd_idx_r  <= odd_idx_nxt;
    end
    if (s1_done) begin
      out_data_r     <= rsp.read_data;
      out_inv_r      <= rsp.wr;
      out_inv_addr_r <= rsp.inv_addr;
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.read_data          = out_data_r;
  assign out_ch.invalidate_valid   = out_inv_r;
  assign out_ch.invalidate_address = out_inv_addr_r;

endmodule

### sv/blmp_chk.sv
module blmp_chk
  import blmp_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [63:0]         out_read_data,
  input logic                out_inv_valid,
  input logic [INV_BITS-1:0] out_inv_addr
);

  // Only one word is in flight between the banks and the result register.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while an access is still in flight");

  a_write_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_inv_valid) |-> (out_read_data == 64'h0))
    else $error("write result carries read data");

  a_no_inv_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_inv_valid) |-> (out_inv_addr == '0))
    else $error("invalidate address set without a write");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_read_data)))
    else $error("stalled result changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_ready))
    else $error("ports active right after reset");

endmodule

bind byte_lane_memory_port_unit blmp_chk u_blmp_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_read_data (out_ch.read_data),
  .out_inv_valid (out_ch.invalidate_valid),
  .out_inv_addr  (out_ch.invalidate_address)
);
